FILE: design/assert_macros.svh
// Assertion macros used by the top level of the sentence parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/nsp_pkg.sv
// Types, constants and header tables of the NMEA sentence parser.
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } nsp_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] field_index;
    logic [7:0] field_char;
    logic       field_empty;
    logic [3:0] header_code;
    logic [2:0] status;
    logic       final_res;
  } nsp_out_t;

  // One queue entry: the results caused by one item, field result first.
  typedef struct packed {
    logic     has_fld;
    nsp_out_t fld;
    logic     has_sts;
    nsp_out_t sts;
  } nsp_entry_t;

  typedef logic [0:6][7:0] nsp_hdr_t;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_DOLLAR   = 3'd1;
  localparam logic [2:0] ST_BAD_SUM     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_HDR = 3'd3;
  localparam logic [2:0] ST_FEW_FIELDS  = 3'd4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam int unsigned NUM_HDR = 10;
  localparam logic [2:0] HDR_MAX_LEN = 3'd7;

  localparam nsp_hdr_t HDR_TEXT [NUM_HDR] = '{
    '{"H", "C", "H", "D", "G", 8'h00, 8'h00},
    '{"W", "I", "M", "W", "V", 8'h00, 8'h00},
    '{"P", "T", "N", "T", "H", "T", "M"},
    '{"G", "P", "V", "T", "G", 8'h00, 8'h00},
    '{"G", "P", "G", "L", "L", 8'h00, 8'h00},
    '{"G", "P", "R", "M", "C", 8'h00, 8'h00},
    '{"G", "P", "G", "G", "A", 8'h00, 8'h00},
    '{"G", "P", "Z", "D", "A", 8'h00, 8'h00},
    '{"W", "I", "M", "D", "A", 8'h00, 8'h00},
    '{"W", "I", "M", "W", "D", 8'h00, 8'h00}
  };

  localparam logic [2:0] HDR_LEN [NUM_HDR] = '{
    3'd5, 3'd5, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] HDR_ARGS [NUM_HDR] = '{
    5'd5, 5'd5, 5'd8, 5'd9, 5'd7, 5'd12, 5'd14, 5'd6, 5'd20, 5'd8
  };

  // First header whose whole text is a prefix of the collected characters.
  function automatic logic [3:0] nsp_hdr_match(input nsp_hdr_t chars, input logic [2:0] len);
    logic [3:0] code;
    logic       ok;
    code = 4'd0;
    for (int h = 0; h < NUM_HDR; h++) begin
      ok = (len >= HDR_LEN[h]);
      for (int i = 0; i < 7; i++) begin
        if ((3'(i) < HDR_LEN[h]) && (chars[i] != HDR_TEXT[h][i])) begin
          ok = 1'b0;
        end
      end
      if (ok && (code == 4'd0)) begin
        code = 4'(h + 1);
      end
    end
    return code;
  endfunction

  function automatic logic [4:0] nsp_field_limit(input logic [3:0] code);
    logic [4:0] lim;
    lim = 5'd0;
    if ((code >= 4'd1) && (code <= 4'(NUM_HDR))) begin
      lim = HDR_ARGS[code - 4'd1];
    end
    return lim;
  endfunction

  function automatic logic [7:0] nsp_hex_value(input logic [7:0] c);
    return (c >= CH_UPPER_A) ? (c - CH_UPPER_A + 8'd10) : (c - CH_ZERO);
  endfunction

endpackage

`default_nettype wire

FILE: design/nsp_front.sv
// Front end: accepts characters, tracks the sentence and forms the results.
`timescale 1ns / 1ps
`default_nettype none

module nsp_front
  import nsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire nsp_in_t    in_data_i,
  output logic            push_o,
  output nsp_entry_t      entry_o
);

  typedef enum logic [2:0] {
    PH_START, PH_SKIP, PH_HEADER, PH_FIELDS, PH_CHK_HI, PH_CHK_LO, PH_DONE
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  nsp_hdr_t   hchars_q, hchars_d;
  logic [2:0] hlen_q, hlen_d;
  logic [3:0] match_q, match_d;
  logic [4:0] fcnt_q, fcnt_d;
  logic       nonempty_q, nonempty_d;
  logic [7:0] given_q, given_d;
  logic       nodollar_q, nodollar_d;

  logic [3:0] hdr_hit;
  logic [4:0] fld_lim;
  logic [7:0] hex;

  assign hdr_hit = nsp_hdr_match(hchars_q, hlen_q);
  assign fld_lim = nsp_field_limit(match_q);
  assign hex     = nsp_hex_value(in_data_i.ch);

  always_comb begin
    logic [7:0] c;
    logic       emit;
    c          = in_data_i.ch;
    emit       = 1'b0;
    phase_d    = phase_q;
    xor_d      = xor_q;
    hchars_d   = hchars_q;
    hlen_d     = hlen_q;
    match_d    = match_q;
    fcnt_d     = fcnt_q;
    nonempty_d = nonempty_q;
    given_d    = given_q;
    nodollar_d = nodollar_q;
    entry_o    = '0;

    if (fire_i) begin
      unique case (phase_q)
        PH_START: begin
          if (c == CH_DOLLAR) begin
            phase_d = PH_HEADER;
          end else begin
            nodollar_d = 1'b1;
            phase_d    = PH_SKIP;
          end
        end
        PH_HEADER: begin
          if (c == CH_STAR) begin
            match_d = hdr_hit;
            phase_d = PH_CHK_HI;
          end else begin
            xor_d = xor_q ^ c;
            if (c == CH_COMMA) begin
              match_d = hdr_hit;
              phase_d = PH_FIELDS;
            end else if (hlen_q < HDR_MAX_LEN) begin
              hchars_d[hlen_q] = c;
              hlen_d           = hlen_q + 3'd1;
            end
          end
        end
        PH_FIELDS: begin
          if (c != CH_STAR) begin
            xor_d = xor_q ^ c;
          end else begin
            phase_d = PH_CHK_HI;
          end
          if ((fcnt_q < fld_lim) && ((c == CH_STAR) || (c == CH_COMMA))) begin
            // close the open field
            emit                      = 1'b1;
            entry_o.fld.kind          = KIND_END;
            entry_o.fld.field_empty   = !nonempty_q;
            fcnt_d                    = fcnt_q + 5'd1;
            nonempty_d                = 1'b0;
          end else if ((fcnt_q < fld_lim) && (c != CH_STAR) && (c != CH_COMMA)) begin
            emit                      = 1'b1;
            entry_o.fld.kind          = KIND_CHAR;
            entry_o.fld.field_char    = c;
            nonempty_d                = 1'b1;
          end
        end
        PH_CHK_HI: begin
          given_d = {hex[3:0], 4'd0};
          phase_d = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          given_d = given_q + hex;
          phase_d = PH_DONE;
        end
        PH_SKIP, PH_DONE: begin
        end
        default: begin
        end
      endcase

      entry_o.has_fld               = emit;
      entry_o.fld.field_index       = fcnt_q;
      entry_o.fld.header_code       = match_d;
      entry_o.fld.final_res         = !in_data_i.last;

      if (in_data_i.last) begin
        entry_o.has_sts         = 1'b1;
        entry_o.sts.kind        = KIND_STATUS;
        entry_o.sts.header_code = match_d;
        entry_o.sts.final_res   = 1'b1;
        priority if (nodollar_d) begin
          entry_o.sts.status = ST_NO_DOLLAR;
        end else if ((phase_d != PH_DONE) || (given_d != xor_d)) begin
          entry_o.sts.status = ST_BAD_SUM;
        end else if (match_d == 4'd0) begin
          entry_o.sts.status = ST_UNKNOWN_HDR;
        end else if (fcnt_d < nsp_field_limit(match_d)) begin
          entry_o.sts.status = ST_FEW_FIELDS;
        end else begin
          entry_o.sts.status = ST_OK;
        end
        // sentence over: back to waiting for a start
        phase_d    = PH_START;
        xor_d      = '0;
        hchars_d   = '0;
        hlen_d     = '0;
        match_d    = '0;
        fcnt_d     = '0;
        nonempty_d = 1'b0;
        given_d    = '0;
        nodollar_d = 1'b0;
      end
    end

    push_o = fire_i && (emit || in_data_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      xor_q      <= '0;
      hchars_q   <= '0;
      hlen_q     <= '0;
      match_q    <= '0;
      fcnt_q     <= '0;
      nonempty_q <= 1'b0;
      given_q    <= '0;
      nodollar_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      xor_q      <= xor_d;
      hchars_q   <= hchars_d;
      hlen_q     <= hlen_d;
      match_q    <= match_d;
      fcnt_q     <= fcnt_d;
      nonempty_q <= nonempty_d;
      given_q    <= given_d;
      nodollar_q <= nodollar_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsp_queue.sv
// Short queue of result entries between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module nsp_queue
  import nsp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire nsp_entry_t entry_i,
  input  wire logic       pop_i,
  output logic            full_o,
  output logic            empty_o,
  output nsp_entry_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  nsp_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/nsp_back.sv
// Back end: drains queue entries into single results on the output register.
`timescale 1ns / 1ps
`default_nettype none

module nsp_back
  import nsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire nsp_entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output nsp_out_t        out_data_o
);

  logic     out_valid_q, out_valid_d;
  nsp_out_t out_data_q, out_data_d;
  logic     sent_q, sent_d;

  always_comb begin
    pop_o       = 1'b0;
    sent_d      = sent_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (head_valid_i) begin
        out_valid_d = 1'b1;
        if (head_i.has_fld && !sent_q) begin
          out_data_d = head_i.fld;
          if (head_i.has_sts) begin
            sent_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_data_d = head_i.sts;
          pop_o      = 1'b1;
          sent_d     = 1'b0;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sent_q      <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: design/nmea_sentence_parser_unit.sv
// Top level of the NMEA sentence parser: front end, result queue, back end.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o | nsp_in_t  (ch, last)
//  out     | output    | out_valid_o/out_ready_i | nsp_out_t (one result item)
//
//  One character is taken per cycle while the queue has room; the front end
//  updates the sentence state and classifies the character in the cycle it
//  is accepted. An item yields up to two results; the back end sends one a
//  cycle while the output is not stalled, the field result before the status.
//  in_ready_o drops only while the result queue is full (QUEUE_DEPTH entries).
//  A stalled output holds its register; the queue absorbs the difference.
//  Reset clears the sentence state, the queue pointers and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_parser_unit
  import nsp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire nsp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output nsp_out_t      out_data_o
);

  logic       in_fire;
  logic       push;
  nsp_entry_t entry;
  logic       q_full, q_empty, pop;
  nsp_entry_t head;

  // accept a character whenever the queue has room for its results
  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  nsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .in_data_i (in_data_i),
    .push_o    (push),
    .entry_o   (entry)
  );

  nsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  nsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // a push must never meet a full queue, or a result is lost
  `ASSERT_AT(a_no_push_full, !(push && q_full), "push into a full result queue")
  // a pop only ever takes an entry that is there
  `ASSERT_AT(a_no_pop_empty, !(pop && q_empty), "pop from an empty result queue")
  // a status result always closes its item
  `ASSERT_IMPLY(a_status_final, out_valid_o && (out_data_o.kind == KIND_STATUS),
                out_data_o.final_res, "status result without final flag")
  // field results never point beyond the largest field count
  `ASSERT_IMPLY(a_field_range, out_valid_o && (out_data_o.kind != KIND_STATUS),
                (out_data_o.field_index <= 5'd19) &&
                ((out_data_o.kind == KIND_CHAR) || (out_data_o.kind == KIND_END)),
                "field result out of range")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the NMEA sentence parser unit.
`timescale 1ns / 1ps

module tb;
  import nsp_pkg::*;

  localparam int          ITEM_TARGET  = 1800;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_OFF     = 64;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;

  typedef enum logic [2:0] {
    SNT_WAIT, SNT_DISCARD, SNT_HDR, SNT_FLD, SNT_SUM_HI, SNT_SUM_LO, SNT_DONE
  } snt_phase_e;

  // One row of the directed table; a typed status replaces the prediction.
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    logic [2:0] sts;
  } dir_row_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready_o;
  nsp_in_t  in_data   = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  nsp_out_t out_data_o;

  // Sideband that travels with the item on the input channel.
  logic       drv_typed = 1'b0;
  logic [2:0] drv_sts   = ST_OK;

  logic       hold_req = 1'b0;
  int         snd_mode = 0;
  int         n_err    = 0;
  int         idle_cnt = 0;

  nsp_out_t   pending_results [$];
  dir_row_t   dir_q [$];
  logic [7:0] snt_q [$];

  // Sentence state as the parser should hold it.
  snt_phase_e p_phase;
  logic [7:0] p_xor;
  logic [7:0] p_hdr [7];
  logic [2:0] p_hdr_len;
  logic [3:0] p_hdr_code;
  logic [4:0] p_fld_cnt;
  logic [7:0] p_fld_len;
  logic [7:0] p_given;
  logic       p_no_dollar;

  nmea_sentence_parser_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sentence predictor
  // ---------------------------------------------------------------------------

  task automatic clear_sentence();
    p_phase = SNT_WAIT;
    p_xor = 8'h00;
    for (int i = 0; i < 7; i++) p_hdr[i] = 8'h00;
    p_hdr_len = 3'd0;
    p_hdr_code = 4'd0;
    p_fld_cnt = 5'd0;
    p_fld_len = 8'd0;
    p_given = 8'h00;
    p_no_dollar = 1'b0;
  endtask

  function automatic logic [4:0] fields_of(input logic [3:0] code);
    if (code == 4'd0 || code > 4'(NUM_HDR)) return 5'd0;
    return HDR_ARGS[code - 4'd1];
  endfunction

  // Walk the table backwards so that the earliest matching prefix wins.
  task automatic lookup_header();
    logic ok;
    p_hdr_code = 4'd0;
    for (int h = NUM_HDR - 1; h >= 0; h--) begin
      ok = (p_hdr_len >= HDR_LEN[h]);
      for (int i = 0; i < 7; i++) begin
        if (i < int'(HDR_LEN[h]) && p_hdr[i] != HDR_TEXT[h][i]) ok = 1'b0;
      end
      if (ok) p_hdr_code = 4'(h + 1);
    end
  endtask

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] base;
    base = (c >= CH_UPPER_A) ? 8'd55 : CH_ZERO;
    return c - base;
  endfunction

  function automatic logic [2:0] sentence_status(input logic [4:0] lim);
    if (p_no_dollar) return ST_NO_DOLLAR;
    if (p_phase != SNT_DONE || p_given != p_xor) return ST_BAD_SUM;
    if (p_hdr_code == 4'd0) return ST_UNKNOWN_HDR;
    if (p_fld_cnt < lim) return ST_FEW_FIELDS;
    return ST_OK;
  endfunction

  function automatic nsp_out_t make_res(input logic [1:0] kind, input logic [4:0] idx,
                                        input logic [7:0] chr, input logic empty,
                                        input logic [2:0] sts);
    nsp_out_t r;
    r.kind = kind;
    r.field_index = idx;
    r.field_char = chr;
    r.field_empty = empty;
    r.header_code = p_hdr_code;
    r.status = sts;
    r.final_res = 1'b0;
    return r;
  endfunction

  // Advance the sentence state by one character and queue what it yields.
  task automatic parse_char(input logic [7:0] c, input logic lst);
    nsp_out_t   res [2];
    int         n;
    logic       close_fld;
    logic [4:0] lim;
    logic [7:0] dv;
    n = 0;
    close_fld = 1'b0;
    lim = fields_of(p_hdr_code);
    case (p_phase)
      SNT_WAIT: begin
        if (c == CH_DOLLAR) begin
          p_phase = SNT_HDR;
        end else begin
          p_no_dollar = 1'b1;
          p_phase = SNT_DISCARD;
        end
      end
      SNT_HDR: begin
        if (c == CH_STAR) begin
          lookup_header();
          p_phase = SNT_SUM_HI;
        end else begin
          p_xor ^= c;
          if (c == CH_COMMA) begin
            lookup_header();
            p_phase = SNT_FLD;
          end else if (p_hdr_len < HDR_MAX_LEN) begin
            p_hdr[p_hdr_len] = c;
            p_hdr_len++;
          end
        end
      end
      SNT_FLD: begin
        if (c == CH_STAR) begin
          close_fld = 1'b1;
          p_phase = SNT_SUM_HI;
        end else begin
          p_xor ^= c;
          if (c == CH_COMMA) begin
            close_fld = 1'b1;
          end else if (p_fld_cnt < lim) begin
            res[n] = make_res(KIND_CHAR, p_fld_cnt, c, 1'b0, ST_OK);
            n++;
            if (p_fld_len != 8'hFF) p_fld_len++;
          end
        end
      end
      SNT_SUM_HI: begin
        dv = digit_value(c);
        p_given = {dv[3:0], 4'h0};
        p_phase = SNT_SUM_LO;
      end
      SNT_SUM_LO: begin
        p_given = p_given + digit_value(c);
        p_phase = SNT_DONE;
      end
      default: ;
    endcase
    lim = fields_of(p_hdr_code);
    if (close_fld && p_fld_cnt < lim) begin
      res[n] = make_res(KIND_END, p_fld_cnt, 8'h00, p_fld_len == 8'd0, ST_OK);
      n++;
      p_fld_cnt++;
      p_fld_len = 8'd0;
    end
    if (lst) begin
      res[n] = make_res(KIND_STATUS, 5'd0, 8'h00, 1'b0, sentence_status(lim));
      n++;
      clear_sentence();
    end
    if (n > 0) res[n - 1].final_res = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  task automatic check_res(input nsp_out_t got);
    nsp_out_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: kind %0d, field %0d", got.kind, got.field_index);
      n_err++;
    end else begin
      want = pending_results.pop_front();
      cmp_field("kind", want.kind, got.kind);
      cmp_field("field_index", want.field_index, got.field_index);
      cmp_field("field_char", want.field_char, got.field_char);
      cmp_field("field_empty", want.field_empty, got.field_empty);
      cmp_field("header_code", want.header_code, got.header_code);
      cmp_field("status", want.status, got.status);
      cmp_field("final_res", want.final_res, got.final_res);
    end
  endtask

  // Predict on every accepted item, then check any result taken in this cycle.
  always @(posedge clk_i) begin
    nsp_out_t t;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        parse_char(in_data.ch, in_data.last);
        if (drv_typed && in_data.last) begin
          t = pending_results.pop_back();
          t.status = drv_sts;
          pending_results.push_back(t);
        end
      end
      if (out_valid_o && out_ready) check_res(out_data_o);
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: phases of no stalls, short stalls and long stalls, plus
  // a long hold-off on each request so that the result queue fills up.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int   stall;
    int   span;
    int   mode;
    int   k;
    logic long_hold;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(50, 300);
      end
      span--;
      long_hold = hold_req;
      stall = 0;
      k = $urandom_range(0, 99);
      if (long_hold) begin
        stall = HOLD_OFF;
      end else if (mode == 1 && k < 30) begin
        stall = $urandom_range(1, 3);
      end else if (mode == 2 && k < 4) begin
        stall = $urandom_range(8, 40);
      end else if (mode == 2 && k < 25) begin
        stall = $urandom_range(1, 2);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        if (long_hold) hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int k;
    if (snd_mode == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one character and hold it until the block takes it.
  task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
                           input logic [2:0] sts);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{ch: c, last: lst};
    drv_typed <= typed;
    drv_sts <= sts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and hold until every predicted result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic dir_row(input logic [7:0] c, input logic lst, input logic typed,
                         input logic [2:0] sts);
    dir_row_t r;
    r.ch = c;
    r.lst = lst;
    r.typed = typed;
    r.sts = sts;
    dir_q.push_back(r);
  endtask

  // A whole sentence as text; its status is typed in on the last character.
  task automatic dir_text(input string s, input logic [2:0] sts);
    for (int i = 0; i < s.len(); i++) begin
      dir_row(s[i], i == s.len() - 1, i == s.len() - 1, sts);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] field_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h30, 8'h5A));
    return 8'($urandom);
  endfunction

  // Build one random sentence into snt_q: mostly well formed with random
  // content, the rest noise, wrong or missing checksums and odd headers.
  task automatic build_sentence();
    int         shape;
    int         hsel;
    int         h;
    int         lim;
    int         nf;
    int         flen;
    int         ck;
    int         cut;
    logic [7:0] sum;
    logic [7:0] sent;
    snt_q.delete();
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      repeat ($urandom_range(1, 8)) snt_q.push_back(8'($urandom));
    end else begin
      snt_q.push_back(CH_DOLLAR);
      hsel = $urandom_range(0, 99);
      if (hsel < 85) begin
        // Known header; a few are cut short, a few carry extra letters.
        h = $urandom_range(0, NUM_HDR - 1);
        lim = HDR_ARGS[h];
        cut = (hsel >= 80) ? 1 : 0;
        for (int i = 0; i < int'(HDR_LEN[h]) - cut; i++) snt_q.push_back(HDR_TEXT[h][i]);
        if (hsel < 8) begin
          repeat ($urandom_range(1, 3)) snt_q.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
        end
      end else begin
        lim = $urandom_range(0, 6);
        repeat ($urandom_range(0, 9)) snt_q.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
      end
      // Star straight after the header in a few sentences.
      if ($urandom_range(0, 99) >= 6) begin
        snt_q.push_back(CH_COMMA);
        nf = ($urandom_range(0, 99) < 70) ? lim : $urandom_range(1, lim + 3);
        if (nf < 1) nf = 1;
        for (int f = 0; f < nf; f++) begin
          if (f > 0) snt_q.push_back(CH_COMMA);
          flen = ($urandom_range(0, 99) < 2) ? $urandom_range(20, 40) : $urandom_range(0, 5);
          repeat (flen) snt_q.push_back(field_byte());
        end
      end
      sum = 8'h00;
      for (int i = 1; i < snt_q.size() && snt_q[i] != CH_STAR; i++) sum ^= snt_q[i];
      ck = $urandom_range(0, 99);
      if (ck < 90) snt_q.push_back(CH_STAR);
      if (ck < 80) begin
        sent = (ck >= 72 && ck < 76) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        snt_q.push_back(hex_char(sent[7:4], ck >= 76));
        snt_q.push_back(hex_char(sent[3:0], ck >= 76));
      end else if (ck < 85) begin
        snt_q.push_back(hex_char(sum[7:4], 1'b0));
      end
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 3)) snt_q.push_back(8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int   n_sent;
    logic mid_drain;
    mid_drain = 1'b0;
    n_sent = 0;
    clear_sentence();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: byte extremes, no dollar, bare dollar, star inside an
    // empty header, and a known header with a character and empty fields.
    dir_row(8'hFF, 1'b1, 1'b1, ST_NO_DOLLAR);
    dir_row(8'h00, 1'b0, 1'b0, ST_OK);
    dir_row(CH_DOLLAR, 1'b1, 1'b1, ST_NO_DOLLAR);
    dir_row(CH_DOLLAR, 1'b1, 1'b1, ST_BAD_SUM);
    dir_text("$*00", ST_UNKNOWN_HDR);
    dir_text("$HCHDG,Z,*1A", ST_FEW_FIELDS);
    snd_mode = 1;
    foreach (dir_q[i]) send_char(dir_q[i].ch, dir_q[i].lst, dir_q[i].typed, dir_q[i].sts);

    // Random sentences; start with a long hold-off on the result side.
    hold_req = 1'b1;
    while (n_sent < ITEM_TARGET) begin
      build_sentence();
      snd_mode = $urandom_range(0, 3);
      if (!mid_drain && n_sent >= ITEM_TARGET / 2) begin
        drain_results();
        hold_req = 1'b1;
        mid_drain = 1'b1;
      end else if ($urandom_range(0, 99) < 5) begin
        drain_results();
      end
      if (snt_q[0] == CH_DOLLAR) n_sent += snt_q.size();
      foreach (snt_q[i]) send_char(snt_q[i], i == snt_q.size() - 1, 1'b0, ST_OK);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/nsp_pkg.sv
design/nsp_front.sv
design/nsp_queue.sv
design/nsp_back.sv
design/nmea_sentence_parser_unit.sv
verif/tb.sv
